@@ src/assert_macros.svh @@
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error("next-cycle check failed");

`endif

@@ src/ptb_pkg.sv @@
`default_nettype none

package ptb_pkg;

    // Command codes carried on the mode field.
    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_START = 2'd1;
    localparam logic [1:0] MODE_STOP  = 2'd2;

    // Width of the timer index fields on the ports.
    localparam int OUT_IDX_W = 4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FLUSH
    } t_state;

endpackage

`default_nettype wire

@@ src/ptb_expiry_unit.sv @@
`default_nettype none

// Decides whether one timer entry has expired and works out its new base.
module ptb_expiry_unit #(
    parameter int TIME_BITS = 32
) (
    input  wire logic                 i_valid,
    input  wire logic [TIME_BITS-1:0] i_since,
    input  wire logic [TIME_BITS-1:0] i_base,
    input  wire logic [TIME_BITS-1:0] i_period,
    input  wire logic [TIME_BITS-1:0] i_now,
    output logic                      o_due,
    output logic [TIME_BITS-1:0]      o_new_base
);

    logic                 w_borrow;
    logic [TIME_BITS-1:0] w_behind;
    logic                 w_snap;

    // The borrow of since minus period is the "not yet due" compare; the
    // difference is how far the timer still lags after one period.
    assign {w_borrow, w_behind} = {1'b0, i_since} - {1'b0, i_period};
    assign o_due  = i_valid && !w_borrow;
    assign w_snap = (w_behind > i_period);
    assign o_new_base = w_snap ? i_now : (i_base + i_period);

endmodule

`default_nettype wire

@@ src/periodic_timer_bank_top.sv @@
`default_nettype none

// Periodic timer bank.
// One command channel: a word is taken at a rising edge where start is high
// and busy is low. The mode field selects a tick, a timer start or a stop.
// A start or stop word is finished in the cycle it is taken, so busy stays
// low and another word may follow in the next cycle. A tick adds its elapsed
// count to the kept time and then walks every timer entry in index order,
// one entry per cycle through the single read port of the entry memory;
// busy stays high until the scan, the drain and the flush are over, so the
// next word is taken only once the previous tick is through.
// Each expired timer produces one result word on o_expired_index, shown for
// exactly one cycle with o_valid high; the receiver cannot hold results off.
// Results leave in index order and o_last_of_run marks the final one of a
// tick. A result leaves once a later expiry or the end of the scan releases
// it; the last one is shown in the first cycle in which busy is low again.
// Reset clears the kept time, every enable bit and the sequencer. The entry
// memory holds period and expiry base and is not cleared: an entry is only
// used while its timer is enabled, and a start always writes it first.
module periodic_timer_bank_top
    import ptb_pkg::*;
#(
    parameter int NUM_TIMERS = 16,
    parameter int TIME_BITS  = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [1:0]           i_mode,
    input  wire logic [OUT_IDX_W-1:0] i_timer_index,
    input  wire logic [31:0]          i_timeout_ms,
    input  wire logic [15:0]          i_elapsed_ms,
    output logic                      o_valid,
    output logic [OUT_IDX_W-1:0]      o_expired_index,
    output logic                      o_last_of_run
);

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int ENT_W = 2 * TIME_BITS;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);
    localparam logic [63:0] TIME_MASK = {64{1'b1}} >> (64 - TIME_BITS);

    // Sequencer.
    t_state r_state;
    t_state n_state;
    logic   w_rd_en;
    logic   w_flush;

    // Command decode.
    logic                 w_accept;
    logic                 w_tick;
    logic                 w_idx_ok;
    logic                 w_start_ok;
    logic                 w_stop_ok;
    logic [IDX_W-1:0]     w_cmd_addr;
    logic [63:0]          w_tmo_ext;
    logic [TIME_BITS-1:0] w_period_in;

    // Kept time and enable bits.
    logic [TIME_BITS-1:0]  r_now;
    logic [NUM_TIMERS-1:0] r_en;

    // Entry memory: expiry base in the upper half, period in the lower half.
    logic [ENT_W-1:0] r_mem [NUM_TIMERS];
    logic [ENT_W-1:0] r_rd_data;
    logic             w_mem_we;
    logic [IDX_W-1:0] w_mem_wa;
    logic [ENT_W-1:0] w_mem_wd;

    // Scan address counter and pipeline.
    logic [IDX_W-1:0]     r_rd_idx;
    logic                 r_s1_vld;
    logic                 r_s1_last;
    logic [IDX_W-1:0]     r_s1_idx;
    logic [TIME_BITS-1:0] w_s1_base;
    logic [TIME_BITS-1:0] w_s1_period;
    logic                 r_s2_vld;
    logic                 r_s2_last;
    logic                 r_s2_en;
    logic [IDX_W-1:0]     r_s2_idx;
    logic [TIME_BITS-1:0] r_s2_since;
    logic [TIME_BITS-1:0] r_s2_base;
    logic [TIME_BITS-1:0] r_s2_period;
    logic                 w_hit;
    logic [TIME_BITS-1:0] w_new_base;

    // A result is held back by one expiry so that the last one of a tick can
    // be flagged once the scan has finished.
    logic                 r_pend_vld;
    logic                 n_pend_vld;
    logic [OUT_IDX_W-1:0] r_pend_idx;
    logic [OUT_IDX_W-1:0] n_pend_idx;
    logic                 r_out_vld;
    logic                 n_out_vld;
    logic [OUT_IDX_W-1:0] r_out_idx;
    logic [OUT_IDX_W-1:0] n_out_idx;
    logic                 r_out_last;
    logic                 n_out_last;

    assign busy     = (r_state != ST_IDLE);
    assign w_accept = start && !busy;
    assign w_tick   = w_accept && (i_mode == MODE_TICK);
    assign w_idx_ok = ({3'b000, i_timer_index} < 7'(NUM_TIMERS));
    assign w_start_ok = w_accept && (i_mode == MODE_START) && w_idx_ok
                        && (i_timeout_ms != 32'd0);
    assign w_stop_ok  = w_accept && (i_mode == MODE_STOP) && w_idx_ok;
    assign w_cmd_addr = IDX_W'(i_timer_index);

    // A period wider than the time word saturates to the largest time value.
    assign w_tmo_ext   = 64'(i_timeout_ms);
    assign w_period_in = (w_tmo_ext > TIME_MASK) ? TIME_MASK[TIME_BITS-1:0]
                                                 : w_tmo_ext[TIME_BITS-1:0];

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_tick) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_rd_idx == LAST_IDX) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (r_s2_vld && r_s2_last) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        w_rd_en = 1'b0;
        w_flush = 1'b0;
        unique case (r_state)
            ST_IDLE:  w_rd_en = 1'b0;
            ST_SCAN:  w_rd_en = 1'b1;
            ST_DRAIN: w_rd_en = 1'b0;
            ST_FLUSH: w_flush = 1'b1;
            default: begin
                w_rd_en = 1'b0;
                w_flush = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_now    <= '0;
            r_en     <= '0;
            r_rd_idx <= '0;
        end else begin
            r_state <= n_state;
            if (w_tick) begin
                r_now    <= r_now + TIME_BITS'(i_elapsed_ms);
                r_rd_idx <= '0;
            end else if (w_rd_en) begin
                r_rd_idx <= r_rd_idx + 1'b1;
            end
            if (w_start_ok) begin
                r_en[w_cmd_addr] <= 1'b1;
            end else if (w_stop_ok) begin
                r_en[w_cmd_addr] <= 1'b0;
            end
        end
    end

    // A start writes in idle, a write-back only during a scan, so the two
    // never meet. Scan write-backs go to an entry already read, so no
    // forwarding is needed.
    always_comb begin
        if (w_start_ok) begin
            w_mem_we = 1'b1;
            w_mem_wa = w_cmd_addr;
            w_mem_wd = {r_now, w_period_in};
        end else begin
            w_mem_we = w_hit;
            w_mem_wa = r_s2_idx;
            w_mem_wd = {w_new_base, r_s2_period};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_wa] <= w_mem_wd;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[r_rd_idx];
        end
    end

    assign w_s1_base   = r_rd_data[ENT_W-1:TIME_BITS];
    assign w_s1_period = r_rd_data[TIME_BITS-1:0];

    // Pipeline control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s1_last <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s2_last <= 1'b0;
        end else begin
            r_s1_vld  <= w_rd_en;
            r_s1_last <= w_rd_en && (r_rd_idx == LAST_IDX);
            r_s2_vld  <= r_s1_vld;
            r_s2_last <= r_s1_vld && r_s1_last;
        end
    end

    // Pipeline payload.
    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_s1_idx <= r_rd_idx;
        end
        if (r_s1_vld) begin
            r_s2_idx    <= r_s1_idx;
            r_s2_en     <= r_en[r_s1_idx];
            r_s2_since  <= r_now - w_s1_base;
            r_s2_base   <= w_s1_base;
            r_s2_period <= w_s1_period;
        end
    end

    ptb_expiry_unit #(
        .TIME_BITS (TIME_BITS)
    ) u_expiry (
        .i_valid    (r_s2_vld && r_s2_en),
        .i_since    (r_s2_since),
        .i_base     (r_s2_base),
        .i_period   (r_s2_period),
        .i_now      (r_now),
        .o_due      (w_hit),
        .o_new_base (w_new_base)
    );

    // Result staging.
    always_comb begin
        n_pend_vld = r_pend_vld;
        n_pend_idx = r_pend_idx;
        n_out_vld  = 1'b0;
        n_out_idx  = r_pend_idx;
        n_out_last = 1'b0;
        priority if (w_hit) begin
            n_out_vld  = r_pend_vld;
            n_pend_vld = 1'b1;
            n_pend_idx = OUT_IDX_W'(r_s2_idx);
        end else if (w_flush) begin
            n_out_vld  = r_pend_vld;
            n_out_last = 1'b1;
            n_pend_vld = 1'b0;
        end else begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_pend_vld <= n_pend_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_idx <= n_pend_idx;
        r_out_idx  <= n_out_idx;
        r_out_last <= n_out_last;
    end

    assign o_valid         = r_out_vld;
    assign o_expired_index = r_out_idx;
    assign o_last_of_run   = r_out_last;

endmodule

`default_nettype wire

@@ src/ptb_checker.sv @@
`default_nettype none

`include "assert_macros.svh"

// Port-level checks on the timer bank.
module ptb_checker
    import ptb_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic [1:0] i_mode,
    input wire logic       o_valid,
    input wire logic       o_last_of_run
);

    // A tick always starts a scan.
    `ASSERT_NEXT(a_tick_scans, i_clk, i_rst_n, start && !busy && (i_mode == MODE_TICK), busy)

    // Start, stop and unused words complete at once.
    `ASSERT_NEXT(a_cmd_quick, i_clk, i_rst_n, start && !busy && (i_mode != MODE_TICK), !busy)

    // Results only follow a cycle in which a scan was running.
    `ASSERT_IMPLIES(a_result_in_scan, i_clk, i_rst_n, o_valid, $past(busy))

    // A result that is not the last one leaves the scan still running.
    `ASSERT_IMPLIES(a_more_pending, i_clk, i_rst_n, o_valid && !o_last_of_run, busy)

    // Nothing follows directly on the last result of a tick.
    `ASSERT_NEXT(a_run_closed, i_clk, i_rst_n, o_valid && o_last_of_run, !o_valid)

endmodule

bind periodic_timer_bank_top ptb_checker u_ptb_checker (.*);

`default_nettype wire

@@ tb/timer_bank_checker.sv @@
`timescale 1ns / 100ps

// Watches the command and expiry channels of the periodic timer bank, keeps its
// own copy of the timers and compares every expiry word with the oldest one
// still owed.
module timer_bank_checker
    import ptb_pkg::*;
#(
    parameter int TIMER_COUNT = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    input  wire logic                 busy,
    input  wire logic [1:0]           i_mode,
    input  wire logic [OUT_IDX_W-1:0] i_timer_index,
    input  wire logic [31:0]          i_timeout_ms,
    input  wire logic [15:0]          i_elapsed_ms,
    input  wire logic                 o_valid,
    input  wire logic [OUT_IDX_W-1:0] o_expired_index,
    input  wire logic                 o_last_of_run,
    output int                        o_error_count,
    output int                        o_outstanding
);

    // Ring of owed expiry words; a tick owes at most one word per timer.
    localparam int OWED_DEPTH = 4 * TIMER_COUNT;

    typedef struct packed {
        logic [OUT_IDX_W-1:0] timer;
        logic                 last;
    } t_expiry;

    logic [31:0]            now_ms;
    logic [31:0]            base_ms   [TIMER_COUNT];
    logic [31:0]            period_ms [TIMER_COUNT];
    logic [TIMER_COUNT-1:0] armed;
    t_expiry                owed_ring [OWED_DEPTH];
    int                     owed_head  = 0;
    int                     owed_count = 0;
    int                     errors = 0;

    assign o_error_count = errors;

    // Appends one word at the tail of the ring.
    task automatic add_owed(input logic [OUT_IDX_W-1:0] timer, input logic last);
        int slot;
        if (owed_count == OWED_DEPTH) begin
            $display("%0t: too many expiry words owed, expected at most %0d actual %0d",
                     $time, OWED_DEPTH, owed_count + 1);
            errors++;
        end else begin
            slot = (owed_head + owed_count) % OWED_DEPTH;
            owed_ring[slot].timer = timer;
            owed_ring[slot].last  = last;
            owed_count++;
        end
    endtask

    // Advances the kept time and queues one word per timer that falls due.
    task automatic run_tick(input logic [15:0] elapsed);
        logic [TIMER_COUNT-1:0] fired;
        logic [31:0]            since;
        int                     last_hit;
        fired    = '0;
        last_hit = -1;
        now_ms   = now_ms + 32'(elapsed);
        for (int i = 0; i < TIMER_COUNT; i++) begin
            since = now_ms - base_ms[i];
            if (armed[i] && since >= period_ms[i]) begin
                base_ms[i] = base_ms[i] + period_ms[i];
                since      = now_ms - base_ms[i];
                // Still more than a period behind: give up catching up.
                if (since > period_ms[i])
                    base_ms[i] = now_ms;
                fired[i] = 1'b1;
                last_hit = i;
            end
        end
        for (int i = 0; i < TIMER_COUNT; i++) begin
            if (fired[i])
                add_owed(OUT_IDX_W'(i), (i == last_hit));
        end
    endtask

    task automatic take_command();
        case (i_mode)
            MODE_TICK: begin
                run_tick(i_elapsed_ms);
            end
            MODE_START: begin
                if (i_timeout_ms != 32'd0) begin
                    period_ms[i_timer_index] = i_timeout_ms;
                    base_ms[i_timer_index]   = now_ms;
                    armed[i_timer_index]     = 1'b1;
                end
            end
            MODE_STOP: begin
                armed[i_timer_index] = 1'b0;
            end
            default: begin
            end
        endcase
    endtask

    task automatic check_expiry();
        t_expiry owed;
        if (owed_count == 0) begin
            $display("%0t: unexpected expiry word, index %0d last %0b",
                     $time, o_expired_index, o_last_of_run);
            errors++;
        end else begin
            owed       = owed_ring[owed_head];
            owed_head  = (owed_head + 1) % OWED_DEPTH;
            owed_count = owed_count - 1;
            if (o_expired_index !== owed.timer) begin
                $display("%0t: expired_index mismatch, expected %0d actual %0d",
                         $time, owed.timer, o_expired_index);
                errors++;
            end
            if (o_last_of_run !== owed.last) begin
                $display("%0t: last_of_run mismatch, expected %0b actual %0b",
                         $time, owed.last, o_last_of_run);
                errors++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            now_ms     = '0;
            armed      = '0;
            owed_head  = 0;
            owed_count = 0;
        end else begin
            // A result leaving in the same cycle as a new tick is taken belongs
            // to the earlier tick, so it is checked first.
            if (o_valid)
                check_expiry();
            if (start && !busy)
                take_command();
        end
        o_outstanding <= owed_count;
    end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

// Top level of the timer bank testbench. It makes the command words, applies
// random idling on the command channel and gives the verdict; all prediction
// and comparison happens in the checker instantiated beside the block.
module tb_top
    import ptb_pkg::*;
();

    localparam int TIMER_COUNT = 16;
    // The block ignores this mode; it has no name in the package.
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int RANDOM_WORDS = 150;
    // Many times the length of the slowest correct run, counting the busy time
    // of every tick and the longest idling gaps.
    localparam int CYCLE_LIMIT = 60000;
    localparam int DRAIN_LIMIT = 2000;
    localparam int TAIL_CYCLES = 30;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic [1:0]           i_mode;
    logic [OUT_IDX_W-1:0] i_timer_index;
    logic [31:0]          i_timeout_ms;
    logic [15:0]          i_elapsed_ms;
    logic                 o_valid;
    logic [OUT_IDX_W-1:0] o_expired_index;
    logic                 o_last_of_run;
    int                   error_count;
    int                   outstanding;
    int                   cycles = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    periodic_timer_bank_top #(
        .NUM_TIMERS (TIMER_COUNT),
        .TIME_BITS  (32)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_mode          (i_mode),
        .i_timer_index   (i_timer_index),
        .i_timeout_ms    (i_timeout_ms),
        .i_elapsed_ms    (i_elapsed_ms),
        .o_valid         (o_valid),
        .o_expired_index (o_expired_index),
        .o_last_of_run   (o_last_of_run)
    );

    timer_bank_checker #(
        .TIMER_COUNT (TIMER_COUNT)
    ) checker_inst (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_mode          (i_mode),
        .i_timer_index   (i_timer_index),
        .i_timeout_ms    (i_timeout_ms),
        .i_elapsed_ms    (i_elapsed_ms),
        .o_valid         (o_valid),
        .o_expired_index (o_expired_index),
        .o_last_of_run   (o_last_of_run),
        .o_error_count   (error_count),
        .o_outstanding   (outstanding)
    );

    // Watchdog: a hung block or a lost handshake ends the run here.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("%0t: cycle limit reached", $time);
            $display("periodic_timer_bank_top test failed");
            $finish;
        end
    end

    // Presents one command word and returns at the edge that takes it. The
    // task is always entered just after a rising edge. When a gap is allowed,
    // start drops for a random number of cycles in about a third of the words,
    // so that new words arrive at every point of a tick's scan.
    task automatic send_word(input logic [1:0] mode, input logic [OUT_IDX_W-1:0] index,
                             input logic [31:0] timeout, input logic [15:0] elapsed,
                             input bit may_idle);
        if (may_idle && $urandom_range(99) < 33) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 24)) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_mode        <= mode;
        i_timer_index <= index;
        i_timeout_ms  <= timeout;
        i_elapsed_ms  <= elapsed;
        // The word is taken at the first edge at which busy is low.
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // Waits until the checker owes no expiry word, with start low so that the
    // word just taken is not offered again. The first edge lets the checker's
    // count take in the word that was just taken.
    task automatic wait_for_quiet();
        start <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    initial begin
        logic [1:0]           mode;
        logic [OUT_IDX_W-1:0] index;
        logic [31:0]          timeout;
        logic [15:0]          elapsed;
        int                   pick;
        int                   waited;

        i_rst_n       <= 1'b0;
        start         <= 1'b0;
        i_mode        <= MODE_TICK;
        i_timer_index <= '0;
        i_timeout_ms  <= '0;
        i_elapsed_ms  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. A tick with every timer idle, a start with a zero
        // period, a stop of an idle timer and a word with the unused mode must
        // all pass without any result.
        send_word(MODE_TICK, '0, 32'd0, 16'd0, 1'b1);
        send_word(MODE_START, '0, 32'd0, 16'd0, 1'b1);
        send_word(MODE_STOP, OUT_IDX_W'(3), 32'd0, 16'd0, 1'b1);
        send_word(MODE_UNUSED, '1, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
        // Arm every timer back to back, with periods one to sixteen.
        for (int n = 0; n < TIMER_COUNT; n++)
            send_word(MODE_START, OUT_IDX_W'(n), 32'(n + 1), 16'd0, 1'b0);
        // The largest step fires all sixteen timers at once, each of them far
        // enough behind that its base snaps to the present time.
        send_word(MODE_TICK, '0, 32'd0, 16'hFFFF, 1'b1);
        // Restart of a running timer with the longest period, then a stop.
        send_word(MODE_START, '1, 32'hFFFF_FFFF, 16'd0, 1'b1);
        send_word(MODE_STOP, OUT_IDX_W'(3), 32'd0, 16'd0, 1'b1);
        // Two milliseconds leave the one-millisecond timer exactly one period
        // behind, so it must fire again on the following tick of zero.
        send_word(MODE_TICK, '0, 32'd0, 16'd2, 1'b1);
        send_word(MODE_TICK, '0, 32'd0, 16'd0, 1'b1);

        // Random part. Mostly starts with short periods and ticks with short
        // steps, so that timers keep firing; now and then a zero, a huge or a
        // fully random value stirs every bit of the fields.
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            index   = OUT_IDX_W'($urandom_range(TIMER_COUNT - 1));
            timeout = $urandom();
            elapsed = 16'($urandom());
            pick    = $urandom_range(99);
            if (pick < 40) begin
                mode = MODE_TICK;
                case ($urandom_range(9))
                    7:       elapsed = 16'd0;
                    8:       ;
                    9:       elapsed = 16'hFFFF;
                    default: elapsed = 16'($urandom_range(30));
                endcase
            end else if (pick < 75) begin
                mode = MODE_START;
                case ($urandom_range(9))
                    6:       timeout = 32'd0;
                    7:       ;
                    8:       timeout = 32'hFFFF_FFFF;
                    9:       timeout = $urandom_range(41, 2000);
                    default: timeout = $urandom_range(1, 40);
                endcase
            end else if (pick < 95) begin
                mode = MODE_STOP;
            end else begin
                mode = MODE_UNUSED;
            end
            // Once, hold back until every owed expiry word has come out.
            if (n == 60)
                wait_for_quiet();
            // A long stretch with start held high wherever the block allows.
            send_word(mode, index, timeout, elapsed, !(n >= 80 && n < 120));
        end
        start <= 1'b0;

        // Let the last tick finish, then watch for stray words a little longer.
        @(posedge i_clk);
        waited = 0;
        while (outstanding != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (outstanding != 0)
            $display("%0t: %0d expiry words never arrived", $time, outstanding);
        if (error_count == 0 && outstanding == 0) begin
            $display("periodic_timer_bank_top test passed");
        end else begin
            $display("periodic_timer_bank_top test failed");
        end
        $finish;
    end

endmodule
